[hw/rtl/lavm_pkg.sv]
package lavm_pkg;

	// Default number of fraction bits in every fixed-point word
	localparam int FRAC_BITS_DEF = 16;

	// Queue depths on either side of the compute engine
	localparam int IN_DEPTH  = 2;
	localparam int OUT_DEPTH = 4;

	// Matrix row numbers
	localparam logic [1:0] ROW_X = 2'd0;
	localparam logic [1:0] ROW_Y = 2'd1;
	localparam logic [1:0] ROW_Z = 2'd2;
	localparam logic [1:0] ROW_W = 2'd3;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
	} item_t;

	typedef struct packed {
		logic [1:0]         row_index;
		logic signed [31:0] col0;
		logic signed [31:0] col1;
		logic signed [31:0] col2;
		logic signed [31:0] col3;
		logic               last_row;
	} row_t;

	// Request into the normalizer: start pulse and the vector to process
	typedef struct packed {
		logic               start;
		logic signed [31:0] v0;
		logic signed [31:0] v1;
		logic signed [31:0] v2;
	} norm_req_t;

endpackage

[hw/rtl/look_at_view_matrix.sv]
// Output: four row words per item at Q16.16, one per cycle unless the result queue is full;
//   a short vector (at or below the threshold) skips the square root and the divider.
// Pacing: a new item is taken only after the rows of the last one are emitted; the shared normalizer,
//   run twice per item, each pass a 32-step square root plus a (FRAC_BITS+1)-step divider, sets it.
// Reset: arst_n clears both queues and all sequencers; no clearing pass.
module look_at_view_matrix import lavm_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         row_index,
	output logic signed [31:0] col0,
	output logic signed [31:0] col1,
	output logic signed [31:0] col2,
	output logic signed [31:0] col3,
	output logic               last_row
);

	item_t in_word;
	item_t head_word;
	logic  in_empty;
	logic  in_pop;
	logic  out_push;
	logic  out_full;
	row_t  row_word;
	row_t  out_word;

	// pack the input word for the front queue
	assign in_word.pos_x = pos_x;
	assign in_word.pos_y = pos_y;
	assign in_word.pos_z = pos_z;
	assign in_word.dir_x = dir_x;
	assign in_word.dir_y = dir_y;
	assign in_word.dir_z = dir_z;

	// front: hold incoming words while the engine works on an earlier one
	lavm_queue #(
		.WIDTH($bits(item_t)),
		.DEPTH(IN_DEPTH)
	) u_in_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (in_word),
		.full  (full),
		.pop   (in_pop),
		.rdata (head_word),
		.empty (in_empty)
	);

	// back: normalize forward and right, build up, dot with the eye, emit rows
	lavm_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(~in_empty),
		.in_item (head_word),
		.in_pop  (in_pop),
		.out_push(out_push),
		.out_row (row_word),
		.out_full(out_full)
	);

	// result queue: one full matrix of rows, so the engine rarely waits on a slow reader
	lavm_queue #(
		.WIDTH($bits(row_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (row_word),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_word),
		.empty (empty)
	);

	assign row_index = out_word.row_index;
	assign col0      = out_word.col0;
	assign col1      = out_word.col1;
	assign col2      = out_word.col2;
	assign col3      = out_word.col3;
	assign last_row  = out_word.last_row;

endmodule

[hw/rtl/lavm_queue.sv]
module lavm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == NW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[hw/rtl/lavm_norm.sv]
module lavm_norm import lavm_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  norm_req_t                 req,
	output logic                      done,
	output logic signed [FRAC_BITS+1:0] q0,
	output logic signed [FRAC_BITS+1:0] q1,
	output logic signed [FRAC_BITS+1:0] q2
);

	localparam int CW = FRAC_BITS + 2;
	localparam int QW = FRAC_BITS + 1;
	localparam int DW = FRAC_BITS + 33;
	localparam int KW = $clog2(FRAC_BITS + 2);
	localparam logic [63:0] EPS_SQ = 64'((64'd1 << (2 * FRAC_BITS)) / 64'd1000000);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_SUM   = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_SQRT  = 3'd4;
	localparam logic [2:0] ST_DIVI  = 3'd5;
	localparam logic [2:0] ST_DIV   = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]         state_q;
	logic [KW-1:0]      cnt_q;
	logic signed [31:0] vin [3];
	logic [31:0]        mag [3];
	logic [31:0]        big;
	logic [63:0]        sq_sum;
	logic [63:0]        trial;
	logic [31:0]        len;
	logic               neg_q [3];
	logic [31:0]        m_q [3];
	logic [CW-1:0]      raw_q [3];
	logic [63:0]        sqp_q [3];
	logic [31:0]        big_q;
	logic [63:0]        sq_q;
	logic               pass_q;
	logic [63:0]        n_q;
	logic [63:0]        root_q;
	logic [63:0]        bit_q;
	logic [DW-1:0]      dsr_q;
	logic [DW-1:0]      rem_q [3];
	logic [QW-1:0]      quo_q [3];
	logic signed [CW-1:0] res [3];

	assign vin[0] = req.v0;
	assign vin[1] = req.v1;
	assign vin[2] = req.v2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = vin[i][31] ? (~vin[i] + 32'd1) : vin[i];
		end
		big = mag[0];
		if (mag[1] > big) big = mag[1];
		if (mag[2] > big) big = mag[2];
		sq_sum = sqp_q[0] + sqp_q[1] + sqp_q[2];
		trial  = root_q + bit_q;
		len    = root_q[31:0];
		for (int i = 0; i < 3; i++) begin
			if (pass_q) begin
				res[i] = raw_q[i];
			end else if (neg_q[i]) begin
				res[i] = -$signed({1'b0, quo_q[i]});
			end else begin
				res[i] = $signed({1'b0, quo_q[i]});
			end
		end
	end

	assign done = (state_q == ST_DONE);
	assign q0   = res[0];
	assign q1   = res[1];
	assign q2   = res[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.start) state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_SUM;
				ST_SUM: begin
					state_q <= (sq_sum <= EPS_SQ) ? ST_DONE : ST_SHIFT;
				end
				ST_SHIFT: begin
					if (big_q >= 32'h4000_0000) state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (bit_q[0]) state_q <= ST_DIVI;
				end
				ST_DIVI: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + KW'(1);
					if (cnt_q == KW'(FRAC_BITS)) state_q <= ST_DONE;
				end
				// a new request may follow straight out of the finished state
				ST_DONE: state_q <= req.start ? ST_MUL : ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE, ST_DONE: begin
				if (req.start) begin
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= vin[i][31];
						m_q[i]   <= mag[i];
						raw_q[i] <= vin[i][CW-1:0];
					end
					big_q  <= big;
					pass_q <= 1'b0;
				end
			end
			ST_MUL: begin
				for (int i = 0; i < 3; i++) sqp_q[i] <= m_q[i] * m_q[i];
			end
			ST_SUM: begin
				sq_q   <= sq_sum;
				pass_q <= (sq_sum <= EPS_SQ);
			end
			ST_SHIFT: begin
				// coarse steps first, then single bits up to the 2^30 mark
				if (big_q < 32'h0040_0000) begin
					big_q <= big_q << 8;
					sq_q  <= sq_q << 16;
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 8;
				end else if (big_q < 32'h4000_0000) begin
					big_q <= big_q << 1;
					sq_q  <= sq_q << 2;
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
				end else begin
					n_q    <= sq_q;
					root_q <= '0;
					bit_q  <= 64'h4000_0000_0000_0000;
				end
			end
			ST_SQRT: begin
				if (n_q >= trial) begin
					n_q    <= n_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_DIVI: begin
				dsr_q <= DW'(len) << FRAC_BITS;
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= (DW'(m_q[i]) << FRAC_BITS) + DW'(len >> 1);
					quo_q[i] <= '0;
				end
			end
			ST_DIV: begin
				for (int i = 0; i < 3; i++) begin
					if (rem_q[i] >= dsr_q) begin
						rem_q[i] <= rem_q[i] - dsr_q;
						quo_q[i] <= {quo_q[i][QW-2:0], 1'b1};
					end else begin
						quo_q[i] <= {quo_q[i][QW-2:0], 1'b0};
					end
				end
				dsr_q <= dsr_q >> 1;
			end
			default: begin
			end
		endcase
	end

endmodule

[hw/rtl/lavm_back.sv]
module lavm_back import lavm_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  item_t in_item,
	output logic  in_pop,
	output logic  out_push,
	output row_t  out_row,
	input  logic  out_full
);

	localparam int CW = FRAC_BITS + 2;
	localparam int UW = FRAC_BITS + 3;
	localparam int PW = 2 * CW;
	localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);
	localparam logic signed [31:0] ONE_FX = 32'sd1 << FRAC_BITS;

	localparam logic [3:0] B_IDLE = 4'd0;
	localparam logic [3:0] B_NF   = 4'd1;
	localparam logic [3:0] B_NR   = 4'd2;
	localparam logic [3:0] B_UM   = 4'd3;
	localparam logic [3:0] B_UR   = 4'd4;
	localparam logic [3:0] B_DM   = 4'd5;
	localparam logic [3:0] B_DS   = 4'd6;
	localparam logic [3:0] B_DR   = 4'd7;
	localparam logic [3:0] B_EMIT = 4'd8;

	// round to nearest, half away from zero, dropping the fraction bits
	function automatic logic signed [63:0] rnd(input logic signed [63:0] x);
		logic [63:0] m;
		logic [63:0] t;
		m = x[63] ? (~x + 64'd1) : x;
		t = (m + HALF) >> FRAC_BITS;
		return x[63] ? $signed(~t + 64'd1) : $signed(t);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (x < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	logic [3:0]            state_q;
	logic [1:0]            row_q;
	norm_req_t             nreq;
	logic                  ndone;
	logic signed [CW-1:0]  nq0, nq1, nq2;
	logic signed [CW-1:0]  neg_f2;

	logic signed [31:0]    px_q, py_q, pz_q;
	logic signed [CW-1:0]  f0_q, f1_q, f2_q;
	logic signed [CW-1:0]  r0_q, r2_q;
	logic signed [PW-1:0]  pa_q, pb_q, pc_q, pd_q;
	logic signed [UW-1:0]  u0_q, u1_q, u2_q;
	logic signed [CW+31:0] rx_q, rz_q, fx_q, fy_q, fz_q;
	logic signed [UW+31:0] ux_q, uy_q, uz_q;
	logic signed [63:0]    sr_q, su_q, sf_q;
	logic signed [31:0]    d0_q, d1_q, d2_q;

	lavm_norm #(
		.FRAC_BITS(FRAC_BITS)
	) u_norm (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (nreq),
		.done  (ndone),
		.q0    (nq0),
		.q1    (nq1),
		.q2    (nq2)
	);

	assign neg_f2 = -nq2;
	assign in_pop = (state_q == B_IDLE) && in_valid;

	always_comb begin
		nreq = '0;
		if (state_q == B_IDLE) begin
			nreq.start = in_valid;
			nreq.v0    = in_item.dir_x;
			nreq.v1    = in_item.dir_y;
			nreq.v2    = in_item.dir_z;
		end else begin
			// right = forward x up(+Y) = (-fz, 0, fx)
			nreq.start = (state_q == B_NF) && ndone;
			nreq.v0    = 32'(neg_f2);
			nreq.v1    = '0;
			nreq.v2    = 32'(nq0);
		end
	end

	assign out_push = (state_q == B_EMIT);

	always_comb begin
		out_row.row_index = row_q;
		out_row.last_row  = (row_q == ROW_W);
		case (row_q)
			ROW_X: begin
				out_row.col0 = 32'(r0_q);
				out_row.col1 = 32'(u0_q);
				out_row.col2 = 32'(-f0_q);
				out_row.col3 = '0;
			end
			ROW_Y: begin
				out_row.col0 = '0;
				out_row.col1 = 32'(u1_q);
				out_row.col2 = 32'(-f1_q);
				out_row.col3 = '0;
			end
			ROW_Z: begin
				out_row.col0 = 32'(r2_q);
				out_row.col1 = 32'(u2_q);
				out_row.col2 = 32'(-f2_q);
				out_row.col3 = '0;
			end
			default: begin
				out_row.col0 = d0_q;
				out_row.col1 = d1_q;
				out_row.col2 = d2_q;
				out_row.col3 = ONE_FX;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			row_q   <= ROW_X;
		end else begin
			case (state_q)
				B_IDLE: if (in_valid) state_q <= B_NF;
				B_NF:   if (ndone) state_q <= B_NR;
				B_NR:   if (ndone) state_q <= B_UM;
				B_UM:   state_q <= B_UR;
				B_UR:   state_q <= B_DM;
				B_DM:   state_q <= B_DS;
				B_DS:   state_q <= B_DR;
				B_DR: begin
					row_q   <= ROW_X;
					state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (!out_full) begin
						row_q <= row_q + 2'd1;
						if (row_q == ROW_W) state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				px_q <= in_item.pos_x;
				py_q <= in_item.pos_y;
				pz_q <= in_item.pos_z;
			end
			B_NF: begin
				f0_q <= nq0;
				f1_q <= nq1;
				f2_q <= nq2;
			end
			B_NR: begin
				r0_q <= nq0;
				r2_q <= nq2;
			end
			B_UM: begin
				pa_q <= r2_q * f1_q;
				pb_q <= r2_q * f0_q;
				pc_q <= r0_q * f2_q;
				pd_q <= r0_q * f1_q;
			end
			B_UR: begin
				// up = right x forward
				u0_q <= UW'(rnd(-64'(pa_q)));
				u1_q <= UW'(rnd(64'(pb_q) - 64'(pc_q)));
				u2_q <= UW'(rnd(64'(pd_q)));
			end
			B_DM: begin
				rx_q <= r0_q * px_q;
				rz_q <= r2_q * pz_q;
				ux_q <= u0_q * px_q;
				uy_q <= u1_q * py_q;
				uz_q <= u2_q * pz_q;
				fx_q <= f0_q * px_q;
				fy_q <= f1_q * py_q;
				fz_q <= f2_q * pz_q;
			end
			B_DS: begin
				sr_q <= 64'(rx_q) + 64'(rz_q);
				su_q <= 64'(ux_q) + 64'(uy_q) + 64'(uz_q);
				sf_q <= 64'(fx_q) + 64'(fy_q) + 64'(fz_q);
			end
			B_DR: begin
				d0_q <= sat32(-rnd(sr_q));
				d1_q <= sat32(-rnd(su_q));
				d2_q <= sat32(rnd(sf_q));
			end
			default: begin
			end
		endcase
	end

endmodule

[bench/look_at_view_matrix_tb.sv]
`timescale 1ns / 100ps

module look_at_view_matrix_tb;
	import lavm_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam longint unsigned EPS_SQ = (64'd1 << (2 * FB)) / 64'd1000000;

	// Keep a signed value within the 32-bit word range.
	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Round away from zero on the half, dropping FB fraction bits.
	function automatic longint round_fx(longint x);
		longint unsigned h;
		h = 64'd1 << (FB - 1);
		if (x >= 0)
			return longint'((unsigned'(x) + h) >> FB);
		return -longint'(((64'd0 - unsigned'(x)) + h) >> FB);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Scale a vector to unit length unless it is no longer than the threshold.
	function automatic void unit_vec(inout longint v[3]);
		longint unsigned m[3];
		longint unsigned sq, big, len, q;
		sq = 0;
		big = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = v[i] < 0 ? 64'd0 - unsigned'(v[i]) : unsigned'(v[i]);
			sq += m[i] * m[i];
			if (m[i] > big)
				big = m[i];
		end
		if (sq <= EPS_SQ)
			return;
		while (big < (64'd1 << 30)) begin
			big <<= 1;
			for (int i = 0; i < 3; i++)
				m[i] <<= 1;
		end
		sq = 0;
		for (int i = 0; i < 3; i++)
			sq += m[i] * m[i];
		len = root_floor(sq);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FB) + (len >> 1)) / len;
			v[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
	endfunction

	class matrix_board;
		row_t rows_due[$];
		int   errors;

		// Work out the four matrix rows of one accepted word.
		function void note_item(item_t it);
			longint p[3], f[3], r[3], u[3], w[3];
			row_t   row;
			p = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
			f = '{longint'(it.dir_x), longint'(it.dir_y), longint'(it.dir_z)};
			unit_vec(f);
			r = '{clamp32(-f[2]), 0, f[0]};
			unit_vec(r);
			u[0] = round_fx(-(r[2] * f[1]));
			u[1] = round_fx(r[2] * f[0] - r[0] * f[2]);
			u[2] = round_fx(r[0] * f[1]);
			w[0] = clamp32(-round_fx(r[0] * p[0] + r[1] * p[1] + r[2] * p[2]));
			w[1] = clamp32(-round_fx(u[0] * p[0] + u[1] * p[1] + u[2] * p[2]));
			w[2] = clamp32(round_fx(f[0] * p[0] + f[1] * p[1] + f[2] * p[2]));
			for (int i = 0; i < 3; i++) begin
				row.row_index = 2'(i);
				row.col0 = 32'(clamp32(r[i]));
				row.col1 = 32'(clamp32(u[i]));
				row.col2 = 32'(clamp32(-f[i]));
				row.col3 = '0;
				row.last_row = 1'b0;
				rows_due.push_back(row);
			end
			row.row_index = ROW_W;
			row.col0 = 32'(w[0]);
			row.col1 = 32'(w[1]);
			row.col2 = 32'(w[2]);
			row.col3 = 32'(64'd1 << FB);
			row.last_row = 1'b1;
			rows_due.push_back(row);
		endfunction

		function void check_row(row_t got);
			row_t want;
			if (rows_due.size() == 0) begin
				$display("%0t: unexpected row word %p", $time, got);
				errors++;
				return;
			end
			want = rows_due.pop_front();
			if (got.row_index !== want.row_index) begin
				$display("%0t: row_index exp %0d got %0d", $time, want.row_index, got.row_index);
				errors++;
			end
			if (got.col0 !== want.col0) begin
				$display("%0t: col0 exp %0d got %0d", $time, want.col0, got.col0);
				errors++;
			end
			if (got.col1 !== want.col1) begin
				$display("%0t: col1 exp %0d got %0d", $time, want.col1, got.col1);
				errors++;
			end
			if (got.col2 !== want.col2) begin
				$display("%0t: col2 exp %0d got %0d", $time, want.col2, got.col2);
				errors++;
			end
			if (got.col3 !== want.col3) begin
				$display("%0t: col3 exp %0d got %0d", $time, want.col3, got.col3);
				errors++;
			end
			if (got.last_row !== want.last_row) begin
				$display("%0t: last_row exp %0d got %0d", $time, want.last_row, got.last_row);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic signed [31:0] pos_x, pos_y, pos_z, dir_x, dir_y, dir_z;
	logic               empty;
	logic               pop;
	logic [1:0]         row_index;
	logic signed [31:0] col0, col1, col2, col3;
	logic               last_row;

	matrix_board board;
	bit          feed_done;

	look_at_view_matrix dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.empty(empty), .pop(pop), .row_index(row_index),
		.col0(col0), .col1(col1), .col2(col2), .col3(col3), .last_row(last_row)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Draw a random word; the mix favors the cases that matter.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'(int'($urandom_range(0, 130)) - 65);
			3: return 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
			4: return '0;
			5: return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
			default: return $urandom;
		endcase
	endfunction

	// Present one word at the falling edge and hold it until accepted.
	task automatic send_word(item_t it);
		int gap;
		gap = $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		{pos_x, pos_y, pos_z, dir_x, dir_y, dir_z} = it;
		push <= 1'b1;
		do
			@(posedge clk);
		while (full);
		board.note_item(it);
		@(negedge clk);
	endtask

	task automatic send_fields(int px, int py, int pz, int dx, int dy, int dz);
		item_t it;
		it = '{px, py, pz, dx, dy, dz};
		send_word(it);
	endtask

	// Receiver: stall at random, sometimes not at all, before each pop.
	initial begin
		int stall;
		pop = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, 10);
			if ($urandom_range(0, 3) == 0)
				stall = 0;
			if (stall != 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			do
				@(posedge clk);
			while (empty);
			board.check_row('{row_index, col0, col1, col2, col3, last_row});
			@(negedge clk);
		end
	end

	initial begin
		item_t it;
		board = new();
		feed_done = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		{pos_x, pos_y, pos_z, dir_x, dir_y, dir_z} = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed: zero, tiny, axis, straight up/down, extremes, big positions.
		send_fields(0, 0, 0, 0, 0, 0);
		send_fields(65536, 0, 0, 0, 0, -65536);
		send_fields(0, 0, 0, 1, 1, 1);
		send_fields(0, 0, 0, 65, 0, 0);
		send_fields(0, 0, 0, 66, 0, 0);
		send_fields(1 << 20, 3 << 16, -5 << 16, 0, 65536, 0);
		send_fields(-(1 << 20), 7, 9, 0, -(1 << 24), 0);
		send_fields(1, 2, 3, 0, 1 << 20, 3);
		send_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_fields(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_fields(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 0, 32'h7FFF_FFFF);
		send_fields(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_fields(-1, -1, -1, -1, -1, -1);
		send_fields(123456, -654321, 99999, 65536, 65536, 65536);
		send_fields(0, 0, 0, 32'h8000_0000, 0, 0);
		push <= 1'b0;

		// Hold off until every expected row has drained.
		while (board.rows_due.size() != 0)
			@(negedge clk);

		for (int n = 0; n < 205; n++) begin
			it = {pick_word(), pick_word(), pick_word(),
				pick_word(), pick_word(), pick_word()};
			send_word(it);
		end
		push <= 1'b0;
		feed_done = 1'b1;
	end

	initial begin
		wait (feed_done);
		while (board.rows_due.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("Verification failed");
		$finish;
	end

endmodule
